// ===== hdl/encoder_pll_phase_estimator_core_assert.svh =====
// Assertion macros for the encoder PLL phase estimator checker.
// No dependencies; taken in by the checker file.
`ifndef ENCODER_PLL_PHASE_ESTIMATOR_CORE_ASSERT_SVH
`define ENCODER_PLL_PHASE_ESTIMATOR_CORE_ASSERT_SVH

// Property checked at every edge, reset included.
`define EPP_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("epp check failed");

// Property checked outside reset only.
`define EPP_CHECK_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("epp check failed");

`endif

// ===== hdl/epp_pkg.sv =====
// Shared types, constants and command codes of the encoder PLL phase estimator.
// No dependencies.
package epp_pkg;

  localparam int POLE_PAIRS = 7;
  localparam int PP_W       = 7;

  localparam int CPR_W   = 19;
  localparam int REM_W   = 18;
  localparam logic [CPR_W-1:0] CPR_MAX = 19'd262144;
  localparam logic [CPR_W-1:0] CPR_RST = 19'd262144;
  localparam logic [15:0]      TS_RST  = 16'd3277;

  localparam int DIV_NW    = 50;
  localparam int DIV_ITER  = DIV_NW / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  localparam int MUL_AW = 41;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic signed [MUL_BW-1:0] FILT_COEF = 20'sd6554;

  typedef enum logic [2:0] {
    CFG_CPR    = 3'd0,
    CFG_DIR    = 3'd1,
    CFG_INTERP = 3'd2,
    CFG_OFFSET = 3'd3,
    CFG_FINE   = 3'd4,
    CFG_KP     = 3'd5,
    CFG_KI     = 3'd6,
    CFG_TS     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] rx_first;
    logic [15:0] rx_second;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] multi_turn_count;
    logic signed [31:0] pos_turns;
    logic signed [31:0] vel_turns;
    logic [23:0]        pos_in_turn;
    logic signed [15:0] elec_phase;
    logic signed [31:0] elec_phase_vel;
    logic               vel_snapped;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_D,
    OP_D,
    OP_DP,
    OP_DIV_E,
    OP_E,
    OP_FE,
    OP_G,
    OP_GE,
    OP_DIV_R,
    OP_R,
    OP_C,
    OP_PH,
    OP_DIV_PH,
    OP_PHQ,
    OP_DIV_PV,
    OP_PVQ,
    OP_POS,
    OP_VEL,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_D,
    S_D,
    S_DP,
    S_DIV_E,
    S_E,
    S_FE,
    S_G,
    S_GE,
    S_DIV_R,
    S_R,
    S_C,
    S_PH,
    S_DIV_PH,
    S_PHQ,
    S_DIV_PV,
    S_PVQ,
    S_POS,
    S_VEL,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/epp_div.sv =====
// Floor divider, signed numerator by unsigned count divisor, two bits a cycle.
// Depends on epp_pkg.
module epp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [epp_pkg::DIV_NW-1:0]  num,
  input  logic [epp_pkg::CPR_W-1:0]          den,
  output logic signed [epp_pkg::DIV_NW-1:0]  quo,
  output logic [epp_pkg::REM_W-1:0]          rem,
  output logic                               done
);
  import epp_pkg::*;

  logic                    busy_r, done_r, neg_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [DIV_NW-1:0]       nq_r;
  logic [REM_W-1:0]        pr_r;
  logic signed [DIV_NW-1:0] quo_r;
  logic [REM_W-1:0]        rem_r;

  logic [CPR_W-1:0]  s1, t1, s2, t2;
  logic              ge1, ge2, last;
  logic [DIV_NW-1:0] nq_nxt;
  logic [REM_W-1:0]  r_mag;

  always_comb begin
    s1     = {pr_r, nq_r[DIV_NW-1]};
    ge1    = (s1 >= den);
    t1     = ge1 ? (s1 - den) : s1;
    s2     = {t1[REM_W-1:0], nq_r[DIV_NW-2]};
    ge2    = (s2 >= den);
    t2     = ge2 ? (s2 - den) : s2;
    nq_nxt = {nq_r[DIV_NW-3:0], ge1, ge2};
    r_mag  = t2[REM_W-1:0];
    last   = (cnt_r == DIV_CNT_W'(DIV_ITER - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DIV_NW-1];
      nq_r  <= num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
      pr_r  <= '0;
    end else if (busy_r) begin
      nq_r <= nq_nxt;
      pr_r <= r_mag;
      if (last) begin
        // floor correction for negative numerators
        if (neg_r) begin
          quo_r <= (r_mag == '0) ? $signed(-nq_nxt) : $signed(~nq_nxt);
          rem_r <= (r_mag == '0) ? r_mag : REM_W'(den - CPR_W'(r_mag));
        end else begin
          quo_r <= $signed(nq_nxt);
          rem_r <= r_mag;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== hdl/epp_dp.sv =====
// Datapath: configuration, loop state, shared multiplier, divider and result word.
// Depends on epp_pkg and epp_div.
module epp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  epp_pkg::dp_cmd_t     cmd,
  output epp_pkg::dp_status_t  status,
  input  epp_pkg::in_word_t    in_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epp_pkg::out_word_t   out_data
);
  import epp_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [DIV_NW-1:0] v);
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // configuration
  logic [CPR_W-1:0] cpr_r;
  logic [1:0]       dir_r;
  logic             interp_en_r;
  logic [17:0]      off_r;
  logic [23:0]      fine_r;
  logic [31:0]      kp_r, ki_r;
  logic [15:0]      ts_r;

  // loop state
  logic [17:0]        last_r;
  logic [31:0]        turn_r;
  logic [33:0]        rev_est_r;
  logic [47:0]        tot_est_r;
  logic signed [31:0] vel_r;
  logic signed [33:0] fe_r;
  logic [23:0]        circ_r;
  logic [16:0]        frac_r;

  // working registers
  logic [17:0]              raw_r;
  logic signed [18:0]       d_r, err_r;
  logic [47:0]              tot_r, tk_r;
  logic signed [51:0]       rev_r;
  logic                     snap_r;
  logic [15:0]              ph_r;
  logic signed [31:0]       pv_r, pos_r;
  logic [31:0]              velq_r;
  logic signed [MUL_PW-1:0] prod_r;
  logic                     out_valid_r;
  out_word_t                out_data_r;

  logic [CPR_W-1:0]         c_eff;
  logic [17:0]              raw_in;
  logic signed [19:0]       wrap_w;
  logic signed [18:0]       wrap_c;
  logic signed [35:0]       diff;
  logic signed [MUL_PW-1:0] rsum;
  logic signed [36:0]       fe_sum;
  logic signed [32:0]       dp;
  logic signed [61:0]       vel_sum;
  logic signed [31:0]       vel_sat, vel_new;
  logic [31:0]              vel_abs;
  logic                     snap;
  logic [33:0]              rev_new;
  logic signed [34:0]       cdiff, fsum;
  logic [16:0]              frac_nxt;
  logic signed [37:0]       phnum;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     mul_en;
  logic                     div_start, div_done;
  logic signed [DIV_NW-1:0] div_num, div_q;
  logic [REM_W-1:0]         div_rem;
  logic [15:0]              ph_out;
  logic signed [31:0]       pv_out;

  epp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (c_eff),
    .quo   (div_q),
    .rem   (div_rem),
    .done  (div_done)
  );

  always_comb begin
    if (cpr_r == '0) begin
      c_eff = CPR_W'(1);
    end else if (cpr_r > CPR_MAX) begin
      c_eff = CPR_MAX;
    end else begin
      c_eff = cpr_r;
    end
  end

  assign raw_in = {in_data.rx_first[7:0], in_data.rx_second[15:10], in_data.rx_second[7:4]};

  // half-turn wrap of the divider remainder; a tie lands on +c/2
  always_comb begin
    if ({div_rem, 1'b0} > c_eff) begin
      wrap_w = $signed({2'b00, div_rem}) - $signed({1'b0, c_eff});
    end else begin
      wrap_w = $signed({2'b00, div_rem});
    end
    wrap_c = wrap_w[18:0];
  end

  always_comb begin
    diff    = $signed({wrap_c[18], wrap_c, 16'h0000}) - 36'(fe_r);
    rsum    = prod_r + MUL_PW'(32768);
    fe_sum  = 37'(fe_r) + 37'($signed(rsum[51:16]));
    dp      = $signed(prod_r[48:16]);
    vel_sum = 62'(vel_r) + 62'(prod_r);
    if (vel_sum > 62'sh7FFF_FFFF) begin
      vel_sat = 32'sh7FFF_FFFF;
    end else if (vel_sum < -62'sh8000_0000) begin
      vel_sat = 32'sh8000_0000;
    end else begin
      vel_sat = vel_sum[31:0];
    end
    vel_abs = vel_sat[31] ? 32'(-vel_sat) : 32'(vel_sat);
    snap    = (48'({vel_abs, 9'h000}) < tk_r);
    vel_new = snap ? 32'sd0 : vel_sat;
    rev_new = {div_rem, rev_r[15:0]};
    cdiff   = $signed({1'b0, rev_new}) - $signed({1'b0, rev_est_r});
    fsum    = $signed({18'h0, frac_r}) + 35'($signed(prod_r[48:16]));
    if (snap_r || !interp_en_r) begin
      frac_nxt = 17'h08000;
    end else if (d_r > 0) begin
      frac_nxt = 17'h00000;
    end else if (d_r < 0) begin
      frac_nxt = 17'h10000;
    end else if (fsum < 0) begin
      frac_nxt = 17'h00000;
    end else if (fsum > 35'sh1_0000) begin
      frac_nxt = 17'h10000;
    end else begin
      frac_nxt = fsum[16:0];
    end
    phnum = ($signed({2'b00, raw_r}) - $signed({2'b00, off_r})) * 38'sd65536
          + $signed({21'h0, frac_r}) - 38'($signed(fine_r)) * 38'sd256;
  end

  // multiplier operand selection
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (cmd.op)
      OP_D: begin
        mul_a = MUL_AW'(vel_r); mul_b = $signed({4'h0, ts_r}); mul_en = 1'b1;
      end
      OP_E: begin
        mul_a = MUL_AW'(diff); mul_b = FILT_COEF; mul_en = 1'b1;
      end
      OP_FE: begin
        mul_a = $signed({9'h000, kp_r}); mul_b = $signed({4'h0, ts_r}); mul_en = 1'b1;
      end
      OP_G: begin
        mul_a = $signed({9'h000, prod_r[47:16]}); mul_b = MUL_BW'(err_r); mul_en = 1'b1;
      end
      OP_GE: begin
        mul_a = $signed({9'h000, ki_r}); mul_b = $signed({4'h0, ts_r}); mul_en = 1'b1;
      end
      OP_DIV_R: begin
        mul_a = $signed({1'b0, prod_r[47:8]}); mul_b = MUL_BW'(err_r); mul_en = 1'b1;
      end
      OP_R: begin
        mul_a = MUL_AW'(vel_new); mul_b = $signed({4'h0, ts_r}); mul_en = 1'b1;
      end
      OP_PH: begin
        mul_a = MUL_AW'(phnum); mul_b = MUL_BW'(POLE_PAIRS); mul_en = 1'b1;
      end
      OP_PHQ: begin
        mul_a = MUL_AW'(vel_r); mul_b = MUL_BW'(POLE_PAIRS); mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    case (cmd.op)
      OP_DIV_D:  div_num = DIV_NW'($signed({1'b0, raw_r}) - $signed({1'b0, last_r}));
      OP_DIV_E:  div_num = DIV_NW'($signed({1'b0, raw_r})) - DIV_NW'($signed(rev_r[51:16]));
      OP_DIV_R:  div_num = DIV_NW'($signed(rev_r[51:16]));
      OP_R:      div_num = DIV_NW'(cdiff) <<< 8;
      OP_DIV_PH: div_num = prod_r[DIV_NW-1:0];
      OP_DIV_PV: div_num = prod_r[DIV_NW-1:0];
      OP_PVQ:    div_num = DIV_NW'($signed(tot_est_r));
      OP_POS:    div_num = DIV_NW'(vel_r);
      default:   div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r       <= CPR_RST;
      dir_r       <= 2'b01;
      interp_en_r <= 1'b1;
      off_r       <= '0;
      fine_r      <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      ts_r        <= TS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CPR:    cpr_r       <= cfg_wdata[CPR_W-1:0];
        CFG_DIR:    dir_r       <= cfg_wdata[1:0];
        CFG_INTERP: interp_en_r <= cfg_wdata[0];
        CFG_OFFSET: off_r       <= cfg_wdata[17:0];
        CFG_FINE:   fine_r      <= cfg_wdata[23:0];
        CFG_KP:     kp_r        <= cfg_wdata;
        CFG_KI:     ki_r        <= cfg_wdata;
        CFG_TS:     ts_r        <= cfg_wdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      turn_r    <= '0;
      rev_est_r <= '0;
      tot_est_r <= '0;
      vel_r     <= '0;
      fe_r      <= '0;
      circ_r    <= '0;
      frac_r    <= '0;
    end else begin
      case (cmd.op)
        OP_D: begin
          turn_r <= turn_r + 32'(wrap_c);
          last_r <= raw_r;
        end
        OP_FE: begin
          if (fe_sum > 37'sh1_FFFF_FFFF) begin
            fe_r <= 34'sh1_FFFF_FFFF;
          end else if (fe_sum < -37'sh2_0000_0000) begin
            fe_r <= -34'sh2_0000_0000;
          end else begin
            fe_r <= fe_sum[33:0];
          end
        end
        OP_R: begin
          rev_est_r <= rev_new;
          tot_est_r <= tot_r;
          vel_r     <= vel_new;
        end
        OP_C: begin
          circ_r <= circ_r + div_q[23:0];
          frac_r <= frac_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LOAD:  raw_r  <= raw_in;
      OP_D:     d_r    <= wrap_c;
      OP_DP: begin
        tot_r <= tot_est_r + 48'(dp);
        rev_r <= $signed({18'h0, rev_est_r}) + 52'(dp);
      end
      OP_E:     err_r  <= wrap_c;
      OP_GE: begin
        tot_r <= tot_r + prod_r[47:0];
        rev_r <= rev_r + prod_r[51:0];
      end
      OP_DIV_R: tk_r   <= prod_r[47:0];
      OP_R:     snap_r <= snap;
      OP_PHQ:   ph_r   <= div_q[15:0];
      OP_PVQ:   pv_r   <= sat32(div_q);
      OP_POS:   pos_r  <= sat32(div_q);
      OP_VEL:   velq_r <= div_q[31:0];
      default: ;
    endcase
  end

  // direction: +1 passes, 0 clears, either negative code negates
  always_comb begin
    priority if (dir_r == 2'b01) begin
      ph_out = ph_r;
      pv_out = pv_r;
    end else if (dir_r == 2'b00) begin
      ph_out = '0;
      pv_out = '0;
    end else begin
      ph_out = 16'(16'h0000 - ph_r);
      pv_out = (pv_r == 32'sh8000_0000) ? 32'sh7FFF_FFFF : 32'(-pv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data_r.multi_turn_count <= $signed(turn_r);
      out_data_r.pos_turns        <= pos_r;
      out_data_r.vel_turns        <= $signed(velq_r);
      out_data_r.pos_in_turn      <= circ_r;
      out_data_r.elec_phase       <= $signed(ph_out);
      out_data_r.elec_phase_vel   <= pv_out;
      out_data_r.vel_snapped      <= snap_r;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// ===== hdl/epp_ctrl.sv =====
// Sequencer: steps the datapath through one sample, waiting on divider and output.
// Depends on epp_pkg.
module epp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  epp_pkg::dp_status_t status,
  output epp_pkg::dp_cmd_t    cmd
);
  import epp_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DIV_D;
      S_DIV_D:   state_nxt = S_D;
      S_D:       if (status.div_done) state_nxt = S_DP;
      S_DP:      state_nxt = S_DIV_E;
      S_DIV_E:   state_nxt = S_E;
      S_E:       if (status.div_done) state_nxt = S_FE;
      S_FE:      state_nxt = S_G;
      S_G:       state_nxt = S_GE;
      S_GE:      state_nxt = S_DIV_R;
      S_DIV_R:   state_nxt = S_R;
      S_R:       if (status.div_done) state_nxt = S_C;
      S_C:       if (status.div_done) state_nxt = S_PH;
      S_PH:      state_nxt = S_DIV_PH;
      S_DIV_PH:  state_nxt = S_PHQ;
      S_PHQ:     if (status.div_done) state_nxt = S_DIV_PV;
      S_DIV_PV:  state_nxt = S_PVQ;
      S_PVQ:     if (status.div_done) state_nxt = S_POS;
      S_POS:     if (status.div_done) state_nxt = S_VEL;
      S_VEL:     if (status.div_done) state_nxt = S_OUT;
      S_OUT:     if (status.out_free) state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DIV_D:  cmd.op = OP_DIV_D;
      S_D:      if (status.div_done) cmd.op = OP_D;
      S_DP:     cmd.op = OP_DP;
      S_DIV_E:  cmd.op = OP_DIV_E;
      S_E:      if (status.div_done) cmd.op = OP_E;
      S_FE:     cmd.op = OP_FE;
      S_G:      cmd.op = OP_G;
      S_GE:     cmd.op = OP_GE;
      S_DIV_R:  cmd.op = OP_DIV_R;
      S_R:      if (status.div_done) cmd.op = OP_R;
      S_C:      if (status.div_done) cmd.op = OP_C;
      S_PH:     cmd.op = OP_PH;
      S_DIV_PH: cmd.op = OP_DIV_PH;
      S_PHQ:    if (status.div_done) cmd.op = OP_PHQ;
      S_DIV_PV: cmd.op = OP_DIV_PV;
      S_PVQ:    if (status.div_done) cmd.op = OP_PVQ;
      S_POS:    if (status.div_done) cmd.op = OP_POS;
      S_VEL:    if (status.div_done) cmd.op = OP_VEL;
      S_OUT:    if (status.out_free) cmd.op = OP_OUT;
    endcase
  end

endmodule

// ===== hdl/encoder_pll_phase_estimator_core.sv =====
// Encoder PLL phase estimator, one sample word in, one result word out.
// Each sample runs eight floor divisions by the count per turn, in sequence in one
// shared two-bit-a-cycle divider, between the other datapath steps.
// One word is processed at a time; the next word is taken while the result waits.
// rst_n is synchronous: loop state clears to zero, registers take their defaults.
// Depends on epp_pkg, epp_ctrl, epp_dp, epp_div.
module encoder_pll_phase_estimator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  epp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output epp_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import epp_pkg::*;

  // Sequencer drives one datapath command a cycle, or none while it waits; the datapath
  // reports divider completion and whether the output register can take a word.
  dp_cmd_t    cmd;
  dp_status_t status;

  epp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: unpacks the angle, wraps the count delta, runs the PI loop
  // through one 41x20 multiplier, and forms phase outputs via the divider.
  epp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/epp_checker.sv =====
// Port-level checker for the encoder PLL phase estimator, bound to the top level.
// Depends on epp_pkg and the assertion macro header.
`include "encoder_pll_phase_estimator_core_assert.svh"

module epp_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input epp_pkg::out_word_t out_data
);
  import epp_pkg::*;

  logic snap_zero_ok;

  assign snap_zero_ok = (out_data.vel_turns == 0) && (out_data.elec_phase_vel == 0);

  `EPP_CHECK_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `EPP_CHECK(a_rst_clears, !rst_n |=> !out_valid)
  `EPP_CHECK_RUN(a_one_at_a_time, in_valid && in_ready |=> !in_ready)
  `EPP_CHECK_RUN(a_snap_zero, out_valid && out_data.vel_snapped |-> snap_zero_ok)

endmodule

bind encoder_pll_phase_estimator_core epp_port_checker u_epp_checker (.*);

// ===== verif/epp_checker.sv =====
// Checker for the encoder PLL phase estimator: watches the channels and config port,
// predicts each result word and compares it. Depends on epp_pkg.
`timescale 1ns / 1ps
module epp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  epp_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  epp_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import epp_pkg::*;

  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  // register copies
  logic [18:0] cpr_r;
  logic [1:0]  dir_r;
  logic        interp_r;
  logic [17:0] offc_r;
  logic [23:0] fine_r;
  logic [31:0] kp_r, ki_r;
  logic [15:0] ts_r;

  // loop state
  logic [17:0] last_cnt;
  logic [31:0] turns;
  longint      rev_est, vel_est, filt_err, frac;
  logic [47:0] total_est;
  logic [23:0] circ_pos;

  out_word_t expected_words[$];

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint pmod(longint a, longint b);
    longint r;
    r = a % b;
    if (r < 0) r += b;
    return r;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_half(longint a, longint c);
    longint m;
    m = pmod(a, c);
    if (2 * m > c) m -= c;
    return m;
  endfunction

  function automatic out_word_t track_sample(in_word_t w);
    out_word_t r;
    longint raw, c, ts, dir, d, dp, tot, rev, prev, err, diff, vel, mag, ph, pv;
    longint g, tk, hi, fine;
    logic [15:0] ph16;
    logic [47:0] t48;
    logic snap;
    raw  = longint'({w.rx_first[7:0], w.rx_second[15:10], w.rx_second[7:4]});
    c    = longint'(cpr_r);
    ts   = longint'(ts_r);
    dir  = longint'(signed'(dir_r));
    fine = longint'(signed'(fine_r));
    snap = 1'b0;
    if (c == 0) c = 1;
    if (c > 262144) c = 262144;

    d = wrap_half(raw - longint'(last_cnt), c);
    turns = turns + d[31:0];
    last_cnt = raw[17:0];

    prev = rev_est;
    vel  = vel_est;
    dp   = fdiv(ts * vel, 65536);
    tot  = longint'(signed'(total_est)) + dp;
    rev  = prev + dp;
    err  = wrap_half(raw - fdiv(rev, 65536), c);

    // error low-pass, round to nearest
    diff = err * 65536 - filt_err;
    filt_err = clampl(filt_err + fdiv(diff * 6554 + 32768, 65536),
                      -(64'sd1 <<< 33), (64'sd1 <<< 33) - 1);

    g   = (ts * longint'(kp_r)) >>> 16;
    tot += g * err;
    rev += g * err;
    rev = pmod(rev, c * 65536);
    t48 = tot[47:0];
    total_est = t48;
    tot = longint'(signed'(t48));
    rev_est = rev;

    tk  = ts * longint'(ki_r);
    hi  = tk >>> 8;
    vel = clampl(vel + hi * err, I32_MIN, I32_MAX);
    mag = vel < 0 ? -vel : vel;
    if ((mag <<< 9) < tk) begin
      vel  = 0;
      snap = 1'b1;
    end
    vel_est = vel;

    circ_pos = circ_pos + 24'(fdiv((rev - prev) * 256, c));

    if (snap || !interp_r) frac = 32768;
    else if (d > 0) frac = 0;
    else if (d < 0) frac = 65536;
    else frac = clampl(frac + fdiv(ts * vel, 65536), 0, 65536);

    ph = fdiv(((raw - longint'(offc_r)) * 65536 + frac - fine * 256) * POLE_PAIRS, c);
    ph16 = ph[15:0];
    pv = clampl(fdiv(vel * POLE_PAIRS, c), I32_MIN, I32_MAX);
    if (dir < 0) begin
      ph16 = 16'(-ph16);
      pv = clampl(-pv, I32_MIN, I32_MAX);
    end else if (dir == 0) begin
      ph16 = '0;
      pv = 0;
    end

    r.multi_turn_count = turns;
    r.pos_turns        = 32'(clampl(fdiv(tot, c), I32_MIN, I32_MAX));
    r.vel_turns        = 32'(fdiv(vel, c));
    r.pos_in_turn      = circ_pos;
    r.elec_phase       = ph16;
    r.elec_phase_vel   = 32'(pv);
    r.vel_snapped      = snap;
    return r;
  endfunction

  task automatic check_field(string f, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, f, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      cpr_r <= CPR_RST; dir_r <= 2'sd1; interp_r <= 1'b1; offc_r <= '0;
      fine_r <= '0; kp_r <= '0; ki_r <= '0; ts_r <= TS_RST;
      last_cnt = '0; turns = '0; rev_est = 0; total_est = '0; vel_est = 0;
      filt_err = 0; circ_pos = '0; frac = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CPR:    cpr_r    <= cfg_wdata[18:0];
          CFG_DIR:    dir_r    <= cfg_wdata[1:0];
          CFG_INTERP: interp_r <= cfg_wdata[0];
          CFG_OFFSET: offc_r   <= cfg_wdata[17:0];
          CFG_FINE:   fine_r   <= cfg_wdata[23:0];
          CFG_KP:     kp_r     <= cfg_wdata;
          CFG_KI:     ki_r     <= cfg_wdata;
          CFG_TS:     ts_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // result side first: a word leaving now belongs to an earlier sample
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          check_field("multi_turn_count", e.multi_turn_count, out_data.multi_turn_count);
          check_field("pos_turns", e.pos_turns, out_data.pos_turns);
          check_field("vel_turns", e.vel_turns, out_data.vel_turns);
          check_field("pos_in_turn", 32'(e.pos_in_turn), 32'(out_data.pos_in_turn));
          check_field("elec_phase", 32'(e.elec_phase), 32'(out_data.elec_phase));
          check_field("elec_phase_vel", e.elec_phase_vel, out_data.elec_phase_vel);
          check_field("vel_snapped", 32'(e.vel_snapped), 32'(out_data.vel_snapped));
        end
      end
      if (in_valid && in_ready) expected_words.push_back(track_sample(in_data));
    end
    pending <= expected_words.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the encoder PLL phase estimator bench: clock, reset, sample stimulus and verdict.
// Depends on epp_pkg, epp_checker and the encoder_pll_phase_estimator_core RTL.
`timescale 1ns / 1ps
module testbench;
  import epp_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0, in_ready;
  in_word_t  in_data = '0;
  logic      out_valid, out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int fail_count, pending;

  bit quiet    = 0;  // no idling in the closing phase
  bit hold_req = 0;  // asks the receiver for one long hold-off
  int sent     = 0;
  int stall_cycles = 0;

  localparam int WATCHDOG_LIMIT = 5000;  // covers one sample's processing, the long receiver hold and a margin

  always #1 clk = ~clk;

  encoder_pll_phase_estimator_core i_dut (.*);

  epp_checker i_checker (.*);

  // Receiver: random back-pressure bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any word accepted on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Register writes: only called with the block idle; enable held over all eight.
  task automatic set_config(logic [31:0] cpr, logic [31:0] dir, logic [31:0] interp,
                            logic [31:0] offc, logic [31:0] fine, logic [31:0] kp,
                            logic [31:0] ki, logic [31:0] ts);
    logic [31:0] vals[8];
    vals = '{cpr, dir, interp, offc, fine, kp, ki, ts};
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one sample word; valid stays up into the next word unless a gap follows.
  task automatic send_word(in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (sent == 300) hold_req = 1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Pack an 18-bit angle into the two sensor words, spare bits random.
  function automatic in_word_t pack_angle(logic [17:0] a);
    in_word_t w;
    w.rx_first  = {8'($urandom), a[17:10]};
    w.rx_second = {a[9:4], 2'($urandom), a[3:0], 4'($urandom)};
    return w;
  endfunction

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Mostly a smoothly turning shaft with jitter; some raw noise words.
  task automatic run_motion(int n, int speed);
    logic [17:0] ang;
    ang = 18'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        ang = ang + 18'(speed + $signed($urandom_range(0, 64)) - 32);
        send_word(pack_angle(ang));
      end else begin
        send_word(in_word_t'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, field extremes, half-turn tie, angle wrap
    send_word('{16'h0000, 16'h0000});
    send_word(pack_angle(18'd131072));   // exactly half a turn away
    send_word('{16'hFFFF, 16'hFFFF});
    send_word('{16'h00FF, 16'hFCF0});
    send_word('{16'hFF00, 16'h030F});
    send_word(pack_angle(18'd0));
    drain();
    // small count per turn: angle beyond range, negative direction, interpolation off
    set_config(32'd1000, 32'h3, 32'd0, 32'd999, 32'h800000, 32'd400000, 32'd1000, 32'd3277);
    send_word(pack_angle(18'd262143));
    send_word(pack_angle(18'd500));
    send_word(pack_angle(18'd1000));
    send_word(pack_angle(18'd1500));
    drain();
    // zero count per turn acts as one; direction zero
    set_config(32'd0, 32'd0, 32'd1, 32'd0, 32'h7FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd65535);
    send_word(pack_angle(18'd12345));
    send_word(pack_angle(18'd54321));
    drain();

    // random phases
    set_config(32'd262144, 32'd1, 32'd1, 32'd1234, 32'd300, 32'd400000, 32'd2000, 32'd3277);
    run_motion(350, 900);
    drain();
    set_config(32'd524287, 32'h2, 32'd1, 32'd262143, 32'hFFFF00, 32'd800000, 32'd50,
               32'd1000);
    run_motion(300, -1500);
    drain();
    set_config(32'd4096, 32'h3, 32'd1, 32'd17, 32'h000123, 32'd2000000, 32'd100000,
               32'd655);
    run_motion(300, 20);
    drain();
    set_config(32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_motion(150, 3);
    drain();
    set_config(32'd100000, 32'd1, 32'd1, 32'd5000, 32'hF00000, $urandom, $urandom,
               $urandom_range(0, 65535));
    run_motion(350, 0);
    drain();
    set_config(32'd262144, 32'd1, 32'd1, 32'd0, 32'd0, 32'd300000, 32'd40, 32'd3277);
    run_motion(250, 200);
    drain();
    quiet = 1;
    set_config(32'd36000, 32'h3, 32'd1, 32'd100, 32'h000080, 32'd600000, 32'd500,
               32'd2000);
    run_motion(300, -400);
    drain();
    repeat (250) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== encoder_pll_phase_estimator_core.f =====
+incdir+hdl
hdl/epp_pkg.sv
hdl/epp_div.sv
hdl/epp_dp.sv
hdl/epp_ctrl.sv
hdl/encoder_pll_phase_estimator_core.sv
hdl/epp_checker.sv
verif/epp_checker.sv
verif/testbench.sv
